[design/ect_pkg.sv]
// Package of the expression tokenizer: widths, codes, token record and character helpers.
package ect_pkg;

  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 12;
  localparam int unsigned MAX_BURST   = 3;

  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] col_t;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    TK_PRINT  = 4'd0,
    TK_NUMBER = 4'd1,
    TK_PLUS   = 4'd2,
    TK_MINUS  = 4'd3,
    TK_STAR   = 4'd4,
    TK_SLASH  = 4'd5,
    TK_LPAREN = 4'd6,
    TK_RPAREN = 4'd7,
    TK_SEMI   = 4'd8,
    TK_EOF    = 4'd9,
    TK_ERROR  = 4'd10
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CHAR  = 2'd1,
    ERR_IDENT = 2'd2
  } err_kind_e;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_INT     = 3'd2,
    MODE_DOT     = 3'd3,
    MODE_FRAC    = 3'd4,
    MODE_SLASH   = 3'd5,
    MODE_COMMENT = 3'd6
  } mode_e;

  // Input function codes.
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Keyword match progress.
  localparam logic [2:0] KP_DONE = 3'd5;
  localparam logic [2:0] KP_NONE = 3'd7;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One result token.
  typedef struct packed {
    tok_kind_e  kind;
    err_kind_e  err;
    logic [7:0] bad;
    line_t      line;
    col_t       col;
    col_t       len;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Letters of the keyword PRINT by position.
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h52;
      3'd2:    r = 8'h49;
      3'd3:    r = 8'h4E;
      3'd4:    r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic col_t col_inc(input col_t v);
    return (v == {COLUMN_BITS{1'b1}}) ? v : v + col_t'(1);
  endfunction

  function automatic line_t line_inc(input line_t v);
    return (v == {LINE_BITS{1'b1}}) ? v : v + line_t'(1);
  endfunction

endpackage

[design/ect_if.sv]
// Stream interfaces of the tokenizer: source bytes in, tokens out.
interface ect_in_if;
  import ect_pkg::*;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink   (input valid, input func, input char_code, output ready);
endinterface

interface ect_out_if;
  import ect_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [1:0]             error_kind;
  logic [7:0]             bad_char;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] start_column;
  logic [COLUMN_BITS-1:0] lexeme_length;
  logic                   last;

  modport source (output valid, output token_kind, output error_kind, output bad_char,
                  output line_number, output start_column, output lexeme_length,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input error_kind, input bad_char,
                  input line_number, input start_column, input lexeme_length,
                  input last, output ready);
endinterface

[design/expression_char_tokenizer.sv]
// Streaming tokenizer for a small expression language.
//
//   Channel  Dir  Payload                                          Accepted when
//   in_i     in   func, char_code                                  valid && ready
//   out_o    out  token_kind, error_kind, bad_char, line_number,   valid && ready
//                 start_column, lexeme_length, last
//
// A byte is scanned in the cycle it is accepted; its tokens (none to three)
// land in a three-slot burst register and leave one per cycle from the next
// while the output is ready. A new byte is taken every cycle while at most one
// token is produced per byte and the output is ready; a byte giving two or three
// tokens holds the input while the burst register drains. A stalled output holds
// its token and blocks input only once the burst register is occupied.
// Reset brings the scanner to the idle mode at line 1, column 1.
module expression_char_tokenizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  ect_in_if.sink           in_i,
  ect_out_if.source        out_o
);
  import ect_pkg::*;

  // Scanner state.
  mode_e      mode_q, mode_d;
  line_t      line_q, line_d;
  col_t       col_q, col_d;
  col_t       tsc_q, tsc_d;
  col_t       tlen_q, tlen_d;
  logic [2:0] kp_q, kp_d;
  col_t       dotc_q, dotc_d;

  // Burst register.
  tok_t       slot_q [MAX_BURST];
  tok_t       slot_d [MAX_BURST];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q;
  logic [1:0] new_cnt;

  logic       in_fire, out_fire, drain_done;
  tok_t       cur_tok;

  // Scan one byte: pending tokens, then the byte's own token, then next state.
  always_comb begin
    logic [7:0] c;
    logic       cont;
    logic       do_flush;
    logic       do_idle;
    tok_t       f0, f1, t;
    logic [1:0] fcnt;
    logic       tv;

    c        = in_i.char_code;
    cont     = 1'b0;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    fcnt     = 2'd0;
    tv       = 1'b0;
    f0       = '{kind: TK_NUMBER, err: ERR_NONE, bad: 8'h00, line: line_q, col: tsc_q,
                 len: tlen_q};
    f1       = '{kind: TK_ERROR, err: ERR_CHAR, bad: CH_DOT, line: line_q, col: dotc_q,
                 len: col_t'(1)};
    t        = '{kind: TK_EOF, err: ERR_NONE, bad: 8'h00, line: line_q, col: col_q,
                 len: col_t'(0)};

    mode_d = mode_q;
    line_d = line_q;
    col_d  = col_q;
    tsc_d  = tsc_q;
    tlen_d = tlen_q;
    kp_d   = kp_q;
    dotc_d = dotc_q;

    // Does the byte extend the current lexeme?
    if (in_i.func == FUNC_CHAR) begin
      case (mode_q)
        MODE_IDENT: begin
          cont = is_alpha(c) || is_digit(c) || (c == CH_US);
          if (cont) begin
            kp_d   = ((kp_q < KP_DONE) && (c == kw_char(kp_q))) ? kp_q + 3'd1 : KP_NONE;
            tlen_d = col_inc(tlen_q);
            col_d  = col_inc(col_q);
          end
        end
        MODE_INT: begin
          cont = is_digit(c) || (c == CH_DOT);
          if (is_digit(c)) begin
            tlen_d = col_inc(tlen_q);
            col_d  = col_inc(col_q);
          end else if (c == CH_DOT) begin
            mode_d = MODE_DOT;
            dotc_d = col_q;
            col_d  = col_inc(col_q);
          end
        end
        MODE_DOT: begin
          cont = is_digit(c);
          if (cont) begin
            mode_d = MODE_FRAC;
            tlen_d = col_inc(col_inc(tlen_q));
            col_d  = col_inc(col_q);
          end
        end
        MODE_FRAC: begin
          cont = is_digit(c);
          if (cont) begin
            tlen_d = col_inc(tlen_q);
            col_d  = col_inc(col_q);
          end
        end
        MODE_SLASH: begin
          cont = (c == CH_SLASH);
          if (cont) begin
            mode_d = MODE_COMMENT;
            col_d  = col_inc(col_q);
          end
        end
        MODE_COMMENT: begin
          cont = (c != CH_LF);
          if (cont) begin
            col_d = col_inc(col_q);
          end
        end
        default: begin
          cont = 1'b0;
        end
      endcase
      do_idle  = !cont;
      do_flush = !cont;
    end else begin
      do_flush = 1'b1;
    end

    // Pending token of the lexeme that ends here.
    if (do_flush) begin
      case (mode_q)
        MODE_IDENT: begin
          fcnt = 2'd1;
          if ((kp_q == KP_DONE) && (tlen_q == col_t'(5))) begin
            f0.kind = TK_PRINT;
          end else begin
            f0.kind = TK_ERROR;
            f0.err  = ERR_IDENT;
          end
        end
        MODE_INT, MODE_FRAC: begin
          fcnt = 2'd1;
        end
        MODE_DOT: begin
          fcnt = 2'd2;
        end
        MODE_SLASH: begin
          fcnt    = 2'd1;
          f0.kind = TK_SLASH;
          f0.len  = col_t'(1);
        end
        default: begin
          fcnt = 2'd0;
        end
      endcase
    end

    // The byte itself, starting from idle.
    if (do_idle) begin
      mode_d = MODE_IDLE;
      t.col  = col_q;
      t.len  = col_t'(1);
      t.kind = TK_ERROR;
      if (c == CH_LF) begin
        line_d = line_inc(line_q);
        col_d  = col_t'(1);
      end else begin
        col_d = col_inc(col_q);
        if (is_space(c)) begin
          tv = 1'b0;
        end else if (is_alpha(c) || (c == CH_US)) begin
          mode_d = MODE_IDENT;
          tsc_d  = col_q;
          tlen_d = col_t'(1);
          kp_d   = (c == kw_char(3'd0)) ? 3'd1 : KP_NONE;
        end else if (is_digit(c)) begin
          mode_d = MODE_INT;
          tsc_d  = col_q;
          tlen_d = col_t'(1);
        end else if (c == CH_SLASH) begin
          mode_d = MODE_SLASH;
          tsc_d  = col_q;
          tlen_d = col_t'(1);
        end else begin
          tv = 1'b1;
          case (c)
            CH_PLUS:  t.kind = TK_PLUS;
            CH_MINUS: t.kind = TK_MINUS;
            CH_STAR:  t.kind = TK_STAR;
            CH_LPAR:  t.kind = TK_LPAREN;
            CH_RPAR:  t.kind = TK_RPAREN;
            CH_SEMI:  t.kind = TK_SEMI;
            default: begin
              t.kind = TK_ERROR;
              t.err  = ERR_CHAR;
              t.bad  = c;
            end
          endcase
        end
      end
    end

    // End of source: EOF token, then back to the reset state.
    if (in_i.func == FUNC_END) begin
      tv     = 1'b1;
      mode_d = MODE_IDLE;
      line_d = line_t'(1);
      col_d  = col_t'(1);
      tsc_d  = '0;
      tlen_d = '0;
      kp_d   = 3'd0;
      dotc_d = '0;
    end

    // Pack the tokens in order.
    slot_d[0] = (fcnt != 2'd0) ? f0 : t;
    slot_d[1] = (fcnt == 2'd2) ? f1 : t;
    slot_d[2] = t;
    new_cnt   = fcnt + {1'b0, tv};
  end

  // Handshakes.
  assign out_fire   = out_o.valid && out_o.ready;
  assign drain_done = out_fire && (idx_q == (cnt_q - 2'd1));
  assign in_i.ready = (cnt_q == 2'd0) || drain_done;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = new_cnt;
    end else if (drain_done) begin
      cnt_d = 2'd0;
    end
  end

  // Scanner state registers, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= line_t'(1);
      col_q  <= col_t'(1);
      tsc_q  <= '0;
      tlen_q <= '0;
      kp_q   <= 3'd0;
      dotc_q <= '0;
    end else if (in_fire) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsc_q  <= tsc_d;
      tlen_q <= tlen_d;
      kp_q   <= kp_d;
      dotc_q <= dotc_d;
    end
  end

  // Burst control: count of tokens held and the one on show.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire || drain_done) begin
        idx_q <= 2'd0;
      end else if (out_fire) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Burst payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_q <= slot_d;
    end
  end

  // Token on show.
  always_comb begin
    case (idx_q)
      2'd0:    cur_tok = slot_q[0];
      2'd1:    cur_tok = slot_q[1];
      default: cur_tok = slot_q[2];
    endcase
  end

  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.token_kind    = cur_tok.kind;
  assign out_o.error_kind    = cur_tok.err;
  assign out_o.bad_char      = cur_tok.bad;
  assign out_o.line_number   = cur_tok.line;
  assign out_o.start_column  = cur_tok.col;
  assign out_o.lexeme_length = cur_tok.len;
  assign out_o.last          = (idx_q == (cnt_q - 2'd1));

endmodule

[design/ect_checker.sv]
// Port-level checks of the tokenizer and their binding to the top level.
module ect_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [3:0]                      token_kind_i,
  input logic [ect_pkg::LINE_BITS-1:0]   line_number_i,
  input logic [ect_pkg::COLUMN_BITS-1:0] start_column_i,
  input logic [ect_pkg::COLUMN_BITS-1:0] lexeme_length_i,
  input logic                            last_i
);
  import ect_pkg::*;

  // A stalled token stays on show unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i)
      && $stable(line_number_i) && $stable(start_column_i) && $stable(lexeme_length_i))
    else $error("stalled token changed");

  // A byte is only taken once the previous burst is gone or leaving.
  a_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || (out_ready_i && last_i))
    else $error("byte accepted while a burst is still held");

  // EOF closes its burst with an empty lexeme.
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == TK_EOF) |-> last_i && (lexeme_length_i == '0))
    else $error("EOF token malformed");

  // Lines and columns count from one.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (line_number_i != '0) && (start_column_i != '0))
    else $error("token position zero");

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .token_kind_i    (out_o.token_kind),
  .line_number_i   (out_o.line_number),
  .start_column_i  (out_o.start_column),
  .lexeme_length_i (out_o.lexeme_length),
  .last_i          (out_o.last)
);
